// ----- sv/keyed_device_table_assert.svh -----
// Assertion macros for the keyed device table.
// Included by the top level; depends on nothing else.
`ifndef KEYED_DEVICE_TABLE_ASSERT_SVH
`define KEYED_DEVICE_TABLE_ASSERT_SVH

// The antecedent holds, so the consequent holds in the same cycle.
`define KDT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds, so the consequent holds in the next cycle.
`define KDT_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/kdt_pkg.sv -----
// Shared types and constants for the keyed device table.
// Used by the controller and the top level; depends on nothing.
`default_nettype none

package kdt_pkg;

    localparam int FUNC_W  = 3;
    localparam int SEL_W   = 2;
    localparam int ID_W    = 48;
    localparam int WDATA_W = 32;
    localparam int RDATA_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 3'd0,
        FUNC_MODIFY = 3'd1,
        FUNC_GET    = 3'd2,
        FUNC_DELETE = 3'd3,
        FUNC_COUNT  = 3'd4
    } func_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

// ----- sv/kdt_ram.sv -----
// Simple dual-port synchronous RAM with a registered read, one write port.
// Used for the key and payload stores; depends on nothing.
`default_nettype none

module kdt_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/kdt_ctrl.sv -----
// Request sequencer of the keyed device table: scans a table through the key
// store, then writes back or reads the payload store. Depends on kdt_pkg.
`default_nettype none

module kdt_ctrl #(
    parameter int NUM_TABLES = 2,
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 48,
    parameter int DATA_BITS  = 32,
    parameter int AW         = 5
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [kdt_pkg::FUNC_W-1:0]  s_func,
    input  wire logic [kdt_pkg::SEL_W-1:0]   s_list_select,
    input  wire logic [kdt_pkg::ID_W-1:0]    s_dev_id,
    input  wire logic [kdt_pkg::WDATA_W-1:0] s_dev_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_status,
    output logic [kdt_pkg::RDATA_W-1:0]      m_read_data,
    output logic [kdt_pkg::COUNT_W-1:0]      m_entry_count,
    output logic                             key_we,
    output logic [AW-1:0]                    key_waddr,
    output logic [KEY_BITS:0]                key_wdata,
    output logic [AW-1:0]                    key_raddr,
    input  wire logic [KEY_BITS:0]           key_rdata,
    output logic                             pay_we,
    output logic [AW-1:0]                    pay_waddr,
    output logic [DATA_BITS-1:0]             pay_wdata,
    output logic [AW-1:0]                    pay_raddr,
    input  wire logic [DATA_BITS-1:0]        pay_rdata
);

    localparam int SLOTS = NUM_TABLES * ENTRIES;
    localparam int EW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int SW    = kdt_pkg::SEL_W;
    localparam int RD_W  = kdt_pkg::RDATA_W;
    localparam int CO_W  = kdt_pkg::COUNT_W;
    localparam logic [SW:0]   NT        = (SW + 1)'(NUM_TABLES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [EW-1:0] LAST_IDX  = EW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_READ,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_idx_reg;
    logic [AW-1:0]         base_reg;
    kdt_pkg::func_t        func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [DATA_BITS-1:0]  data_reg;
    logic [EW-1:0]         scan_idx_reg;
    logic                  chk_vld_reg;
    logic [EW-1:0]         chk_idx_reg;
    logic                  hit_reg;
    logic [EW-1:0]         hit_idx_reg;
    logic                  free_reg;
    logic [EW-1:0]         free_idx_reg;
    logic [CW-1:0]         count_reg;
    logic                  res_status_reg;
    logic [RD_W-1:0]       res_data_reg;
    logic [CO_W-1:0]       res_count_reg;
    logic                  m_valid_reg;
    logic                  m_status_reg;
    logic [RD_W-1:0]       m_read_data_reg;
    logic [CO_W-1:0]       m_entry_count_reg;

    logic                  s_good;
    logic [AW-1:0]         hit_addr;
    logic [AW-1:0]         free_addr;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_data   = m_read_data_reg;
    assign m_entry_count = m_entry_count_reg;

    assign s_good    = ({1'b0, s_list_select} < NT) && (s_func <= kdt_pkg::FUNC_COUNT);
    assign hit_addr  = base_reg + AW'(hit_idx_reg);
    assign free_addr = base_reg + AW'(free_idx_reg);

    // Accesses to the stores never overlap: a request only scans after the
    // previous one has finished its write-back.
    always_comb begin
        key_we    = 1'b0;
        key_waddr = hit_addr;
        key_wdata = {1'b0, key_reg};
        key_raddr = base_reg + AW'(scan_idx_reg);
        pay_we    = 1'b0;
        pay_waddr = hit_addr;
        pay_wdata = data_reg;
        pay_raddr = hit_addr;
        unique case (state_reg)
            ST_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = clr_idx_reg;
                key_wdata = '0;
            end
            ST_DECIDE: begin
                case (func_reg)
                    kdt_pkg::FUNC_ADD: begin
                        if (!hit_reg && free_reg) begin
                            key_we    = 1'b1;
                            key_waddr = free_addr;
                            key_wdata = {1'b1, key_reg};
                            pay_we    = 1'b1;
                            pay_waddr = free_addr;
                        end
                    end
                    kdt_pkg::FUNC_MODIFY: begin
                        pay_we = hit_reg;
                    end
                    kdt_pkg::FUNC_DELETE: begin
                        key_we = hit_reg;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            chk_vld_reg <= (state_reg == ST_SCAN);
            chk_idx_reg <= scan_idx_reg;

            if (chk_vld_reg) begin
                if (key_rdata[KEY_BITS]) begin
                    count_reg <= count_reg + CW'(1);
                    if (key_rdata[KEY_BITS-1:0] == key_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= chk_idx_reg;
                    end
                end else if (!free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= chk_idx_reg;
                end
            end

            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                    if (clr_idx_reg == LAST_SLOT) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        base_reg       <= AW'(int'(s_list_select) * ENTRIES);
                        func_reg       <= kdt_pkg::func_t'(s_func);
                        key_reg        <= KEY_BITS'(s_dev_id);
                        data_reg       <= DATA_BITS'(s_dev_data);
                        scan_idx_reg   <= '0;
                        hit_reg        <= 1'b0;
                        free_reg       <= 1'b0;
                        count_reg      <= '0;
                        res_status_reg <= kdt_pkg::STATUS_ERR;
                        res_data_reg   <= '0;
                        res_count_reg  <= '0;
                        state_reg      <= s_good ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    scan_idx_reg <= scan_idx_reg + EW'(1);
                    if (scan_idx_reg == LAST_IDX) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    case (func_reg)
                        kdt_pkg::FUNC_ADD: begin
                            res_status_reg <= (!hit_reg && !free_reg) ? kdt_pkg::STATUS_ERR
                                                                      : kdt_pkg::STATUS_OK;
                            state_reg      <= ST_DONE;
                        end
                        kdt_pkg::FUNC_GET: begin
                            res_status_reg <= hit_reg ? kdt_pkg::STATUS_OK
                                                      : kdt_pkg::STATUS_ERR;
                            state_reg      <= hit_reg ? ST_READ : ST_DONE;
                        end
                        kdt_pkg::FUNC_COUNT: begin
                            res_status_reg <= kdt_pkg::STATUS_OK;
                            res_count_reg  <= CO_W'(count_reg);
                            state_reg      <= ST_DONE;
                        end
                        default: begin
                            res_status_reg <= kdt_pkg::STATUS_OK;
                            state_reg      <= ST_DONE;
                        end
                    endcase
                end
                ST_READ: begin
                    res_data_reg <= RD_W'(pay_rdata);
                    state_reg    <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= res_status_reg;
                        m_read_data_reg   <= res_data_reg;
                        m_entry_count_reg <= res_count_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/keyed_device_table.sv -----
// Keyed device table: several exact-match tables of device records, each
// request one beat in and one result beat out.
//
// The request channel (s_valid, s_ready, s_func, s_list_select, s_dev_id,
// s_dev_data) carries one operation per beat: add, modify, get, delete or
// count on one table. The result channel (m_valid, m_ready, m_status,
// m_read_data, m_entry_count) returns exactly one beat per request, in order.
// A request walks the selected table through the key store, one entry per
// cycle, then writes back or reads the payload store. After acceptance a
// request passes through the scan, drain and decide states, then a payload
// read for a successful get, and its result beat is loaded in the done
// state; only then is the next request taken. A bad table or operation goes
// from acceptance straight to the done state. The entry scan over the single
// read port of the key store sets how long a request takes.
// After reset the block sweeps all NUM_TABLES * ENTRIES key store entries,
// one entry a cycle, with s_ready low; all tables are then empty.
// A result waits in its output register while m_ready is low; the next
// request may be accepted and processed meanwhile, and it holds its result
// until the register is free.
// Depends on kdt_pkg, kdt_ctrl, kdt_ram and keyed_device_table_assert.svh.
`default_nettype none

`include "keyed_device_table_assert.svh"

module keyed_device_table #(
    parameter int NUM_TABLES = 2,
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 48,
    parameter int DATA_BITS  = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [kdt_pkg::FUNC_W-1:0]  s_func,
    input  wire logic [kdt_pkg::SEL_W-1:0]   s_list_select,
    input  wire logic [kdt_pkg::ID_W-1:0]    s_dev_id,
    input  wire logic [kdt_pkg::WDATA_W-1:0] s_dev_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_status,
    output logic [kdt_pkg::RDATA_W-1:0]      m_read_data,
    output logic [kdt_pkg::COUNT_W-1:0]      m_entry_count
);

    localparam int SLOTS = NUM_TABLES * ENTRIES;
    localparam int AW    = $clog2(SLOTS);

    logic                 key_we;
    logic [AW-1:0]        key_waddr;
    logic [KEY_BITS:0]    key_wdata;
    logic [AW-1:0]        key_raddr;
    logic [KEY_BITS:0]    key_rdata;
    logic                 pay_we;
    logic [AW-1:0]        pay_waddr;
    logic [DATA_BITS-1:0] pay_wdata;
    logic [AW-1:0]        pay_raddr;
    logic [DATA_BITS-1:0] pay_rdata;

    kdt_ctrl #(
        .NUM_TABLES (NUM_TABLES),
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .DATA_BITS  (DATA_BITS),
        .AW         (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_list_select (s_list_select),
        .s_dev_id      (s_dev_id),
        .s_dev_data    (s_dev_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_data   (m_read_data),
        .m_entry_count (m_entry_count),
        .key_we        (key_we),
        .key_waddr     (key_waddr),
        .key_wdata     (key_wdata),
        .key_raddr     (key_raddr),
        .key_rdata     (key_rdata),
        .pay_we        (pay_we),
        .pay_waddr     (pay_waddr),
        .pay_wdata     (pay_wdata),
        .pay_raddr     (pay_raddr),
        .pay_rdata     (pay_rdata)
    );

    kdt_ram #(
        .WIDTH (KEY_BITS + 1),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kdt_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    `KDT_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && (m_status == kdt_pkg::STATUS_ERR), (m_read_data == '0) && (m_entry_count == '0), "error result carries data")
    `KDT_ASSERT_NEXT(a_one_at_a_time, aclk, s_valid && s_ready, !s_ready, "second request taken while busy")
    `KDT_ASSERT_NEXT(a_reset_busy, aclk, !aresetn, !s_ready, "request taken during the clearing sweep")

endmodule

`default_nettype wire
